### sv/rpwu_pkg.sv
package rpwu_pkg;

   // default number of weights kept in the state memory
   localparam int WEIGHT_COUNT_DEF = 1024;

   // payload widths
   localparam int INDEX_W  = 10;
   localparam int WEIGHT_W = 32;
   localparam int STEP_W   = 31;
   localparam int DEC_W    = 16;
   localparam int INC_W    = 20;
   localparam int SIGN_W   = 2;
   localparam int FRAC_W   = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = 3;

   localparam logic [REG_SEL_W-1:0] REG_DECREASE = 3'd0;
   localparam logic [REG_SEL_W-1:0] REG_INCREASE = 3'd1;
   localparam logic [REG_SEL_W-1:0] REG_MIN_STEP = 3'd2;
   localparam logic [REG_SEL_W-1:0] REG_MAX_STEP = 3'd3;
   localparam logic [REG_SEL_W-1:0] REG_INIT_STEP = 3'd4;

   // register reset values
   localparam logic [DEC_W-1:0]  DECREASE_RST  = 16'd32768;
   localparam logic [INC_W-1:0]  INCREASE_RST  = 20'd78643;
   localparam logic [STEP_W-1:0] MIN_STEP_RST  = 31'd1;
   localparam logic [STEP_W-1:0] MAX_STEP_RST  = 31'd3276800;
   localparam logic [STEP_W-1:0] INIT_STEP_RST = 31'd6554;

   // stored gradient sign codes
   localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
   localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
   localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

   // state memory word: valid, previous sign, step
   localparam int ENTRY_W = 1 + SIGN_W + STEP_W;

   typedef struct packed {
      logic [DEC_W-1:0]  decrease_factor;
      logic [INC_W-1:0]  increase_factor;
      logic [STEP_W-1:0] min_step;
      logic [STEP_W-1:0] max_step;
      logic [STEP_W-1:0] initial_step;
   } rpwu_cfg_type;

endpackage

### sv/rpwu_ram.sv
module rpwu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/rpwu_csr.sv
module rpwu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rpwu_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rpwu_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rpwu_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output rpwu_pkg::rpwu_cfg_type              cfg
);

   import rpwu_pkg::*;

   rpwu_cfg_type             cfg_ff;
   rpwu_cfg_type             cfg_in;
   logic                     wr_stb;
   logic [REG_SEL_W-1:0]     reg_sel;

   assign pready  = 1'b1;
   assign wr_stb  = psel && penable && pwrite;
   assign reg_sel = paddr[CSR_ADDR_W-1:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_sel)
            REG_DECREASE:  cfg_in.decrease_factor = pwdata[DEC_W-1:0];
            REG_INCREASE:  cfg_in.increase_factor = pwdata[INC_W-1:0];
            REG_MIN_STEP:  cfg_in.min_step        = pwdata[STEP_W-1:0];
            REG_MAX_STEP:  cfg_in.max_step        = pwdata[STEP_W-1:0];
            REG_INIT_STEP: cfg_in.initial_step    = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decrease_factor <= DECREASE_RST;
         cfg_ff.increase_factor <= INCREASE_RST;
         cfg_ff.min_step        <= MIN_STEP_RST;
         cfg_ff.max_step        <= MAX_STEP_RST;
         cfg_ff.initial_step    <= INIT_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         REG_DECREASE:  prdata = CSR_DATA_W'(cfg_ff.decrease_factor);
         REG_INCREASE:  prdata = CSR_DATA_W'(cfg_ff.increase_factor);
         REG_MIN_STEP:  prdata = CSR_DATA_W'(cfg_ff.min_step);
         REG_MAX_STEP:  prdata = CSR_DATA_W'(cfg_ff.max_step);
         REG_INIT_STEP: prdata = CSR_DATA_W'(cfg_ff.initial_step);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### sv/rprop_weight_update_unit.sv
// iRprop- weight update unit. Pulse start with an index, weight and gradient
// while busy is low; the item is taken at that edge and its result shows on
// the rsp_ ports for exactly one cycle, flagged by rsp_valid, after the step
// multiply on the memory read data, step clamp, weight update and write back
// and the result register. The results cannot be held off, so capture them
// when rsp_valid is high. One item is in flight at a time: busy stays high
// after the accepting edge until those steps are done, so a new item can be
// taken only once the last one is written back. The per-weight state lives
// in a single-port-read memory of WEIGHT_COUNT words. After reset the block
// runs a clearing pass over that memory with busy high; configuration writes
// are taken during it. Configuration must only be written while no item is
// in flight.
module rprop_weight_update_unit #(
   parameter int WEIGHT_COUNT = rpwu_pkg::WEIGHT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [rpwu_pkg::INDEX_W-1:0]        req_weight_index,
   input  logic signed [rpwu_pkg::WEIGHT_W-1:0] req_weight_value,
   input  logic signed [rpwu_pkg::WEIGHT_W-1:0] req_gradient,
   // result channel
   output logic                                rsp_valid,
   output logic [rpwu_pkg::INDEX_W-1:0]        rsp_result_index,
   output logic signed [rpwu_pkg::WEIGHT_W-1:0] rsp_new_weight,
   output logic [rpwu_pkg::STEP_W-1:0]         rsp_new_step,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rpwu_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rpwu_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rpwu_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import rpwu_pkg::*;

   localparam int ADDR_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
   localparam int WIDE_W = 17;
   localparam int PROD_W = STEP_W + INC_W;
   localparam int SCALED_W = PROD_W - FRAC_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WEIGHT_COUNT - 1);
   localparam logic [WIDE_W-1:0] COUNT_WIDE = WIDE_W'(WEIGHT_COUNT);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_CLAMP = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   // step rule codes
   localparam logic [1:0] MODE_KEEP   = 2'd0;
   localparam logic [1:0] MODE_GROW   = 2'd1;
   localparam logic [1:0] MODE_SHRINK = 2'd2;

   rpwu_cfg_type cfg;

   logic [2:0]                 state_ff, state_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic                       accept;

   logic [INDEX_W-1:0]         idx_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;
   logic signed [WEIGHT_W-1:0] grad_ff;
   logic                       in_range_ff;
   logic [ADDR_W-1:0]          addr_ff;

   logic [ENTRY_W-1:0]         rd_entry;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [ENTRY_W-1:0]         ram_wdata;
   logic [WIDE_W-1:0]          req_idx_wide;
   logic [ADDR_W-1:0]          req_addr;

   logic                       use_entry;
   logic [STEP_W-1:0]          step_sel;
   logic [SIGN_W-1:0]          prev_sign;
   logic [SIGN_W-1:0]          gsign;
   logic [1:0]                 mode_in;
   logic [INC_W-1:0]           factor;
   logic [PROD_W-1:0]          prod_in, prod_ff;
   logic [STEP_W-1:0]          old_step_ff;
   logic [1:0]                 mode_ff;
   logic [SIGN_W-1:0]          gsign_ff;

   logic [SCALED_W-1:0]        scaled;
   logic [STEP_W-1:0]          step_in, step_ff;

   logic signed [WEIGHT_W+1:0] wext, sext, sum;
   logic signed [WEIGHT_W-1:0] new_weight;
   logic [SIGN_W-1:0]          new_sign;

   logic                       rsp_valid_ff;
   logic [INDEX_W-1:0]         rsp_index_ff;
   logic signed [WEIGHT_W-1:0] rsp_weight_ff;
   logic [STEP_W-1:0]          rsp_step_ff;

   rpwu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign req_idx_wide = WIDE_W'(req_weight_index);
   assign req_addr     = req_idx_wide[ADDR_W-1:0];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff      <= req_weight_index;
         weight_ff   <= req_weight_value;
         grad_ff     <= req_gradient;
         in_range_ff <= (req_idx_wide < COUNT_WIDE);
         addr_ff     <= req_addr;
      end
   end

   // state memory: clearing pass, then write back of each item
   assign ram_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_WRITE) && in_range_ff);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : {1'b1, new_sign, step_ff};

   rpwu_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (WEIGHT_COUNT),
      .ADDR_W (ADDR_W)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_entry)
   );

   // entry select, step rule and step multiply
   always_comb begin
      use_entry = in_range_ff && rd_entry[ENTRY_W-1];
      step_sel  = use_entry ? rd_entry[STEP_W-1:0] : cfg.initial_step;
      prev_sign = use_entry ? rd_entry[STEP_W +: SIGN_W] : SIGN_ZERO;
      if (grad_ff > 0) begin
         gsign = SIGN_POS;
      end else if (grad_ff < 0) begin
         gsign = SIGN_NEG;
      end else begin
         gsign = SIGN_ZERO;
      end
      if ((prev_sign != SIGN_ZERO) && (gsign != SIGN_ZERO)) begin
         mode_in = (prev_sign == gsign) ? MODE_GROW : MODE_SHRINK;
      end else begin
         mode_in = MODE_KEEP;
      end
      factor  = (mode_in == MODE_GROW) ? cfg.increase_factor
                                       : INC_W'(cfg.decrease_factor);
      prod_in = PROD_W'(step_sel) * PROD_W'(factor);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff     <= prod_in;
         old_step_ff <= step_sel;
         mode_ff     <= mode_in;
         gsign_ff    <= gsign;
      end
   end

   // cap or floor the scaled step, or keep the old step
   assign scaled = prod_ff[PROD_W-1:FRAC_W];

   always_comb begin
      case (mode_ff)
         MODE_GROW: begin
            if (scaled > SCALED_W'(cfg.max_step)) begin
               step_in = cfg.max_step;
            end else begin
               step_in = scaled[STEP_W-1:0];
            end
         end
         MODE_SHRINK: begin
            if (scaled < SCALED_W'(cfg.min_step)) begin
               step_in = cfg.min_step;
            end else begin
               step_in = scaled[STEP_W-1:0];
            end
         end
         default: step_in = old_step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLAMP) begin
         step_ff <= step_in;
      end
   end

   // weight update with saturation; weight held on a sign change
   always_comb begin
      wext = (WEIGHT_W + 2)'(weight_ff);
      sext = $signed({3'b000, step_ff});
      if (gsign_ff == SIGN_POS) begin
         sum = wext - sext;
      end else if (gsign_ff == SIGN_NEG) begin
         sum = wext + sext;
      end else begin
         sum = wext;
      end
      if (mode_ff == MODE_SHRINK) begin
         new_weight = weight_ff;
      end else if (sum[WEIGHT_W+1:WEIGHT_W-1] == 3'b000 ||
                   sum[WEIGHT_W+1:WEIGHT_W-1] == 3'b111) begin
         new_weight = sum[WEIGHT_W-1:0];
      end else if (sum[WEIGHT_W+1]) begin
         new_weight = {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
         new_weight = {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
      new_sign = (mode_ff == MODE_SHRINK) ? SIGN_ZERO : gsign_ff;
   end

   // result register, one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         rsp_index_ff  <= idx_ff;
         rsp_weight_ff <= new_weight;
         rsp_step_ff   <= step_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_new_weight   = rsp_weight_ff;
   assign rsp_new_step     = rsp_step_ff;

   // a result only follows the write-back step
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_WRITE))
      else $error("result strobe without write-back");

   // one item in flight: strobes never come in adjacent cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back result strobes");

   // the multiply step is only entered from an accepted item
   a_mul_from_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> $past(accept))
      else $error("multiply step without accepted item");

   // no item is taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("item taken during clearing pass");

endmodule
